### rtl/core/arc_pkg.sv
// Shared types, request codes and address checks for the address resolution cache.
// No dependencies; used by arc_ctrl, arc_dp and address_resolution_cache.
package arc_pkg;

	localparam int MODE_W = 2;
	localparam int IP_W = 32;
	localparam int MAC_W = 48;
	localparam int TIME_W = 64;
	localparam int COUNT_W = 5;

	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd2;

	localparam logic [7:0] MCAST_FIRST = 8'd224;
	localparam logic [7:0] MCAST_LAST = 8'd239;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch request, clear scan trackers
		logic rd_en;  // table read issued this cycle
		logic commit; // write back and present result
	} dp_cmd_t;

	// zero, multicast block and limited broadcast are refused
	function automatic logic ip_usable(input logic [IP_W-1:0] ip);
		logic [7:0] top;
		top = ip[31:24];
		ip_usable = (ip != '0) && !(top >= MCAST_FIRST && top <= MCAST_LAST) && (ip != '1);
	endfunction

	// zero and group addresses are refused
	function automatic logic mac_usable(input logic [MAC_W-1:0] mac);
		mac_usable = !mac[40] && (mac != '0);
	endfunction

endpackage

### rtl/core/arc_ctrl.sv
// Sequencer for the address resolution cache: idle, table scan, drain, commit.
// Depends on arc_pkg (command struct).
module arc_ctrl #(
	parameter int ENTRIES = 16,
	parameter int IDX_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output arc_pkg::dp_cmd_t    cmd,
	output logic [IDX_W-1:0]    rd_addr
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [1:0] state_q;
	logic [IDX_W-1:0] addr_q;

	assign busy = (state_q != ST_IDLE);
	assign rd_addr = addr_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.rd_en = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/arc_dp.sv
// Datapath for the address resolution cache: entry memory, valid flags,
// per-entry match/free/oldest/expiry evaluation and result registers. Uses arc_pkg.
module arc_dp #(
	parameter int ENTRIES = 16,
	parameter int IDX_W = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  arc_pkg::dp_cmd_t                  cmd,
	input  logic [IDX_W-1:0]                  rd_addr,
	input  logic [arc_pkg::TIME_W-1:0]        max_age,
	input  logic [arc_pkg::MODE_W-1:0]        mode,
	input  logic [arc_pkg::IP_W-1:0]          protocol_address,
	input  logic [arc_pkg::MAC_W-1:0]         hardware_address,
	input  logic [arc_pkg::TIME_W-1:0]        now,
	output logic                              done,
	output logic                              success,
	output logic [arc_pkg::MAC_W-1:0]         found_hardware_address,
	output logic [arc_pkg::COUNT_W-1:0]       expired_count
);

	// request
	logic [arc_pkg::MODE_W-1:0] mode_q;
	logic [arc_pkg::IP_W-1:0] ip_q;
	logic [arc_pkg::MAC_W-1:0] mac_q;
	logic [arc_pkg::TIME_W-1:0] now_q;

	// table
	logic [arc_pkg::IP_W-1:0] mem_ip [ENTRIES];
	logic [arc_pkg::MAC_W-1:0] mem_mac [ENTRIES];
	logic [arc_pkg::TIME_W-1:0] mem_ts [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// read stage
	logic v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [arc_pkg::IP_W-1:0] ip_s1;
	logic [arc_pkg::MAC_W-1:0] mac_s1;
	logic [arc_pkg::TIME_W-1:0] ts_s1;

	// scan trackers
	logic match_found_q, free_found_q, oldest_found_q;
	logic [IDX_W-1:0] match_idx_q, free_idx_q, oldest_idx_q;
	logic [arc_pkg::MAC_W-1:0] match_mac_q;
	logic [arc_pkg::TIME_W-1:0] oldest_ts_q;
	logic [arc_pkg::COUNT_W-1:0] count_q;

	logic ip_ok, upd_ok, ent_valid, ent_match, ent_expire, exp_en;
	logic [arc_pkg::TIME_W-1:0] age;
	logic [IDX_W-1:0] target;

	assign ip_ok = arc_pkg::ip_usable(ip_q);
	assign upd_ok = (mode_q == arc_pkg::MODE_UPDATE) && ip_ok && arc_pkg::mac_usable(mac_q);
	assign exp_en = (mode_q == arc_pkg::MODE_EXPIRE) && (max_age != '0);
	assign ent_valid = valid_q[idx_s1];
	assign ent_match = ent_valid && (ip_s1 == ip_q);
	assign age = now_q - ts_s1;
	assign ent_expire = exp_en && ent_valid && (now_q >= ts_s1) && (age >= max_age);

	always_comb begin
		if (match_found_q) begin
			target = match_idx_q;
		end else if (free_found_q) begin
			target = free_idx_q;
		end else if (oldest_found_q) begin
			target = oldest_idx_q;
		end else begin
			target = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			ip_q <= protocol_address;
			mac_q <= hardware_address;
			now_q <= now;
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && upd_ok) begin
			mem_ip[target] <= ip_q;
			mem_mac[target] <= mac_q;
			mem_ts[target] <= now_q;
		end
		ip_s1 <= mem_ip[rd_addr];
		mac_s1 <= mem_mac[rd_addr];
		ts_s1 <= mem_ts[rd_addr];
		idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			if (v_s1 && ent_expire) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (cmd.commit && upd_ok) begin
				valid_q[target] <= 1'b1;
			end
		end
	end

	// first match wins; oldest keeps the lowest index on ties; free keeps the highest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
			oldest_found_q <= 1'b0;
			count_q <= '0;
		end else if (cmd.load) begin
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
			oldest_found_q <= 1'b0;
			count_q <= '0;
		end else if (v_s1) begin
			if (ent_expire && count_q != arc_pkg::COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			if (!match_found_q) begin
				if (ent_match) begin
					match_found_q <= 1'b1;
				end else if (ent_valid) begin
					if (!oldest_found_q || ts_s1 < oldest_ts_q) begin
						oldest_found_q <= 1'b1;
					end
				end else begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !match_found_q) begin
			if (ent_match) begin
				match_idx_q <= idx_s1;
				match_mac_q <= mac_s1;
			end else if (ent_valid) begin
				if (!oldest_found_q || ts_s1 < oldest_ts_q) begin
					oldest_idx_q <= idx_s1;
					oldest_ts_q <= ts_s1;
				end
			end else begin
				free_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (mode_q == arc_pkg::MODE_UPDATE) begin
				success <= upd_ok;
				found_hardware_address <= '0;
			end else if (mode_q == arc_pkg::MODE_LOOKUP && ip_ok && match_found_q) begin
				success <= 1'b1;
				found_hardware_address <= match_mac_q;
			end else begin
				success <= 1'b0;
				found_hardware_address <= '0;
			end
			expired_count <= (mode_q == arc_pkg::MODE_EXPIRE) ? count_q : '0;
		end
	end

endmodule

### rtl/core/address_resolution_cache.sv
// Address resolution cache: IPv4 -> Ethernet table with update, lookup, expiry.
// A request walks all table entries, then drains and commits; done follows commit.
// Requests are taken one at a time (busy low), as set by the single table read port
//   walked once per request; start is taken again in the cycle done is high.
// Reset (arst_n low, asynchronous): valid flags cleared, max_age = 0, sequencer idle.
// Results cannot be stalled: each shows for one cycle with done.
module address_resolution_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  logic [arc_pkg::MODE_W-1:0]    mode,
	input  logic [arc_pkg::IP_W-1:0]      protocol_address,
	input  logic [arc_pkg::MAC_W-1:0]     hardware_address,
	input  logic [arc_pkg::TIME_W-1:0]    now,
	// result channel
	output logic                          done,
	output logic                          success,
	output logic [arc_pkg::MAC_W-1:0]     found_hardware_address,
	output logic [arc_pkg::COUNT_W-1:0]   expired_count,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	arc_pkg::dp_cmd_t cmd;
	logic [IDX_W-1:0] rd_addr;
	logic [arc_pkg::TIME_W-1:0] max_age_q;
	logic reg_sel;

	// max_age sits at byte 0; paddr[3] selects the (empty) next slot
	assign pready = 1'b1;
	assign reg_sel = !paddr[3];
	assign prdata = reg_sel ? max_age_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_age_q <= pwdata;
		end
	end

	// sequencer: walks table addresses, then drains and commits
	arc_ctrl #(
		.ENTRIES(ENTRIES),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	// table, per-entry evaluation and result registers
	arc_dp #(
		.ENTRIES(ENTRIES),
		.IDX_W(IDX_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.max_age(max_age_q),
		.mode(mode),
		.protocol_address(protocol_address),
		.hardware_address(hardware_address),
		.now(now),
		.done(done),
		.success(success),
		.found_hardware_address(found_hardware_address),
		.expired_count(expired_count)
	);

	// an accepted request keeps the block busy for the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// a result strobe follows a commit cycle only
	a_done_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.commit))
		else $error("result strobe without commit");

	// successful requests never report expirations
	a_success_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && success) |-> (expired_count == '0))
		else $error("success together with expired count");

	// no result while a scan is still under way
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && cmd.rd_en) |-> !done)
		else $error("result strobe during table scan");

endmodule
